// ===== sv/fcache_pkg.sv =====
// ----------------------------------------------------------------------------
// fcache_pkg
// types and command codes shared by the keyed cache and its entry cells
// ----------------------------------------------------------------------------
package fcache_pkg;

  localparam logic [2:0] CMD_LOOKUP    = 3'd0;
  localparam logic [2:0] CMD_STORE     = 3'd1;
  localparam logic [2:0] CMD_INV_KEY   = 3'd2;
  localparam logic [2:0] CMD_INV_GRAPH = 3'd3;
  localparam logic [2:0] CMD_CLEAR     = 3'd4;

  typedef struct packed {
    logic [2:0]  command;
    logic [63:0] graph_hash;
    logic [63:0] dependency_hash;
    logic [63:0] include_hash;
    logic [63:0] combined_hash;
    logic [63:0] payload_in;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] payload_out;
    logic [4:0]  removed_count;
    logic [4:0]  entry_count;
    logic [31:0] eviction_total;
  } rsp_t;

  typedef struct packed {
    logic [63:0] graph_hash;
    logic [63:0] dependency_hash;
    logic [63:0] include_hash;
    logic [63:0] combined_hash;
    logic [63:0] payload;
  } entry_t;

  typedef struct packed {
    logic   valid;
    logic   mark;
    entry_t ent;
  } cell_st_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic pay_we;
    logic mark_full;
    logic mark_graph;
    logic clear;
  } cell_ctl_t;

endpackage

// ===== sv/fcache_cell.sv =====
// ----------------------------------------------------------------------------
// fcache_cell
// one table entry: key compare, mark for removal, shift from upper neighbor
// ----------------------------------------------------------------------------
module fcache_cell
  import fcache_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  logic      carry_i,
  input  cell_st_t  nb_i,
  input  req_t      req_i,
  output logic      carry_o,
  output cell_st_t  st_o,
  output logic      hit_full_o,
  output logic      hit_graph_o
);

  logic   valid_q, valid_d;
  logic   mark_q, mark_d;
  entry_t ent_q, ent_d;
  logic   take;

  assign hit_graph_o = valid_q && (ent_q.graph_hash == req_i.graph_hash);
  assign hit_full_o  = hit_graph_o
                    && (ent_q.dependency_hash == req_i.dependency_hash)
                    && (ent_q.include_hash == req_i.include_hash)
                    && (ent_q.combined_hash == req_i.combined_hash);

  // shift chain: this cell and all above a marked cell move down one place
  assign take    = carry_i || (mark_q && valid_q);
  assign carry_o = take;
  assign st_o    = '{valid: valid_q, mark: mark_q, ent: ent_q};

  always_comb begin
    valid_d = valid_q;
    mark_d  = mark_q;
    ent_d   = ent_q;
    if (ctl_i.clear) begin
      valid_d = 1'b0;
      mark_d  = 1'b0;
    end else if (ctl_i.shift && take) begin
      valid_d = nb_i.valid;
      mark_d  = nb_i.mark;
      ent_d   = nb_i.ent;
    end else if (ctl_i.load) begin
      valid_d = 1'b1;
      mark_d  = 1'b0;
      ent_d   = '{graph_hash: req_i.graph_hash, dependency_hash: req_i.dependency_hash,
                  include_hash: req_i.include_hash, combined_hash: req_i.combined_hash,
                  payload: req_i.payload_in};
    end else if (ctl_i.mark_full) begin
      mark_d = hit_full_o;
    end else if (ctl_i.mark_graph) begin
      mark_d = hit_graph_o;
    end else if (ctl_i.pay_we && hit_full_o) begin
      ent_d.payload = req_i.payload_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      mark_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      mark_q  <= mark_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

// ===== sv/fifo_evicting_keyed_cache.sv =====
// ----------------------------------------------------------------------------
// fifo_evicting_keyed_cache
// fully associative keyed cache with oldest-first replacement
// ----------------------------------------------------------------------------
// Entries live in a row of cells, oldest in cell 0. Every cell compares its key
// against the request at once; removal and eviction shift the cells above the
// removed entry down by one place per cycle. A request passes the accept,
// capacity check, execute and result steps; the capacity check and a store
// into a full table first evict oldest entries, and the invalidate commands
// add a compaction step that shifts out each removed entry. The result
// register lets a new request be accepted while the previous result waits.
module fifo_evicting_keyed_cache
  import fcache_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  req_t       req_i,
  output logic       rsp_valid_o,
  input  logic       rsp_ready_i,
  output rsp_t       rsp_o,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_data_i
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = (CW > 5) ? CW : 5;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_PRE     = 3'd1;
  localparam logic [2:0] S_EXEC    = 3'd2;
  localparam logic [2:0] S_COMPACT = 3'd3;
  localparam logic [2:0] S_DONE    = 3'd4;

  logic [2:0]    st_q, st_d;
  req_t          req_q;
  logic [4:0]    cap_q;
  logic [CW-1:0] cnt_q, cnt_d, eff_cap;
  logic [CW-1:0] rem_q, rem_d;
  logic [31:0]   ev_q, ev_d;
  logic          hit_q, hit_d;
  logic [63:0]   pay_q, pay_d;
  logic          rsp_valid_q;
  rsp_t          rsp_q;

  cell_ctl_t     bc;
  logic          evict, load_en;
  logic [TABLE_DEPTH:0]   carry;
  cell_st_t      st_c [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] hit_full, hit_graph, valid_v, mark_v;
  logic [63:0]   pay_or;

  always_comb begin
    if (cap_q == 5'd0 || EW'(cap_q) > EW'(TABLE_DEPTH)) begin
      eff_cap = DEPTH_C;
    end else begin
      eff_cap = CW'(cap_q);
    end
  end

  assign carry[0] = evict;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    cell_ctl_t ctl;
    cell_st_t  nb;
    always_comb begin
      ctl      = bc;
      ctl.load = load_en && (cnt_q == CW'(g));
    end
    if (g == TABLE_DEPTH - 1) begin : g_top
      assign nb = '0;
    end else begin : g_mid
      assign nb = st_c[g+1];
    end
    fcache_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .carry_i     (carry[g]),
      .nb_i        (nb),
      .req_i       (req_q),
      .carry_o     (carry[g+1]),
      .st_o        (st_c[g]),
      .hit_full_o  (hit_full[g]),
      .hit_graph_o (hit_graph[g])
    );
    assign valid_v[g] = st_c[g].valid;
    assign mark_v[g]  = st_c[g].mark && st_c[g].valid;
  end

  // keys are unique in the table, so at most one payload passes
  always_comb begin
    pay_or = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      pay_or = pay_or | (st_c[i].ent.payload & {64{hit_full[i]}});
    end
  end

  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    ev_d    = ev_q;
    hit_d   = hit_q;
    pay_d   = pay_q;
    bc      = '0;
    evict   = 1'b0;
    load_en = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (req_valid_i) begin
          st_d  = S_PRE;
          rem_d = '0;
          hit_d = 1'b0;
          pay_d = '0;
        end
      end
      S_PRE: begin
        if (cnt_q > eff_cap) begin
          evict    = 1'b1;
          bc.shift = 1'b1;
          cnt_d    = cnt_q - 1'b1;
          if (ev_q != '1) ev_d = ev_q + 1'b1;
        end else begin
          st_d = S_EXEC;
        end
      end
      S_EXEC: begin
        st_d = S_DONE;
        unique case (req_q.command)
          CMD_LOOKUP: begin
            hit_d = |hit_full;
            pay_d = pay_or;
          end
          CMD_STORE: begin
            if (|hit_full) begin
              bc.pay_we = 1'b1;
            end else if (cnt_q >= eff_cap) begin
              st_d     = S_EXEC;
              evict    = 1'b1;
              bc.shift = 1'b1;
              cnt_d    = cnt_q - 1'b1;
              if (ev_q != '1) ev_d = ev_q + 1'b1;
            end else begin
              load_en = 1'b1;
              cnt_d   = cnt_q + 1'b1;
            end
          end
          CMD_INV_KEY: begin
            bc.mark_full = 1'b1;
            st_d         = S_COMPACT;
          end
          CMD_INV_GRAPH: begin
            bc.mark_graph = 1'b1;
            st_d          = S_COMPACT;
          end
          CMD_CLEAR: begin
            bc.clear = 1'b1;
            cnt_d    = '0;
            ev_d     = '0;
          end
          default: begin
          end
        endcase
      end
      S_COMPACT: begin
        if (|mark_v) begin
          bc.shift = 1'b1;
          cnt_d    = cnt_q - 1'b1;
          rem_d    = rem_q + 1'b1;
        end else begin
          if (req_q.command == CMD_INV_KEY) hit_d = (rem_q != '0);
          st_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp_ready_i) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      cap_q       <= '0;
      cnt_q       <= '0;
      ev_q        <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      ev_q  <= ev_d;
      if (cfg_we_i) cap_q <= cfg_data_i;
      if (st_q == S_DONE && (!rsp_valid_q || rsp_ready_i)) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    hit_q <= hit_d;
    pay_q <= pay_d;
    if (st_q == S_IDLE && req_valid_i) req_q <= req_i;
    if (st_q == S_DONE && (!rsp_valid_q || rsp_ready_i)) begin
      rsp_q.hit            <= hit_q;
      rsp_q.payload_out    <= pay_q;
      rsp_q.removed_count  <= (req_q.command == CMD_INV_GRAPH) ? 5'(EW'(rem_q)) : 5'd0;
      rsp_q.entry_count    <= 5'(EW'(cnt_q));
      rsp_q.eviction_total <= ev_q;
    end
  end

  assign req_ready_o = (st_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_C) else $error("entry count above table depth");
  a_cnt_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_IDLE |-> $countones(valid_v) == int'(cnt_q))
    else $error("entry count disagrees with valid cells");
  a_no_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_DONE |-> mark_v == '0) else $error("marked entry left after removal");
`endif

endmodule
